// ===== hw/rtl/cbm_pkg.sv =====
// Shared types and constants for the cartridge bank mapper.
`timescale 1ns / 1ps

package cbm_pkg;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_LAYOUT = 1'b0,
    CFG_STEP   = 1'b1
  } cfg_idx_e;

  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 8;
  localparam logic [7:0]  StepReset = 8'd114;

  // Depth of the command queue between decode and execute
  localparam int unsigned CbmQueueDepth = 2;

  // Input operation codes
  localparam logic OpWrite = 1'b0;
  localparam logic OpTick  = 1'b1;

  // Full-address layout register window
  localparam logic [11:0] FullBase = 12'h800;

  // Decoded command kinds
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CHR,
    CMD_PRG_DIRECT,
    CMD_OUTER_LOW,
    CMD_OUTER_HIGH,
    CMD_INNER,
    CMD_MIRROR,
    CMD_IRQ_CTRL,
    CMD_RELOAD_LO,
    CMD_RELOAD_HI,
    CMD_TICK
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [2:0] slot;
    logic [7:0] data;
  } cmd_t;

  // Queue status seen by the top level
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // One result item
  typedef struct packed {
    logic       chr_update;
    logic [2:0] chr_slot;
    logic [7:0] chr_bank;
    logic       prg_low_update;
    logic [8:0] prg_low_bank;
    logic       prg_high_update;
    logic [4:0] prg_high_bank;
    logic       mirror_update;
    logic [1:0] mirror_mode;
    logic       irq_fire;
  } result_t;

endpackage

// ===== hw/rtl/cartridge_bank_mapper_with_irq.sv =====
// Top level of the cartridge bank mapper with scanline IRQ counter.
//
// Takes one register write or scanline tick per cycle while the queue has room
// and returns exactly one result per item, one per clock while results are
// taken. A transfer on the input is decoded in the same cycle and lands in a
// two-entry command queue; the execute stage takes one command per cycle while
// the result register is free or taken (a 16-bit compare and subtract for
// ticks) into the result register, and the input keeps flowing while a result
// waits to be taken until the queue fills. Configuration (layout mode, line
// step) is to be written by the user through the cfg port only while the block
// is idle (not enforced) and takes effect at once; there is no clearing pass.
`timescale 1ns / 1ps

module cartridge_bank_mapper_with_irq import cbm_pkg::*; #(
  parameter int unsigned QueueDepth = CbmQueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // input channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                operation_i,
  input  logic [15:0]         address_i,
  input  logic [7:0]          write_data_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                chr_update_o,
  output logic [2:0]          chr_slot_o,
  output logic [7:0]          chr_bank_o,
  output logic                prg_low_update_o,
  output logic [8:0]          prg_low_bank_o,
  output logic                prg_high_update_o,
  output logic [4:0]          prg_high_bank_o,
  output logic                mirror_update_o,
  output logic [1:0]          mirror_mode_o,
  output logic                irq_fire_o
);

  logic        layout_q;
  logic [7:0]  step_q;
  cmd_t        front_cmd, queue_cmd;
  logic        queue_valid, queue_pop;
  queue_stat_t queue_stat;
  result_t     res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layout_q <= 1'b0;
      step_q   <= StepReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LAYOUT: layout_q <= cfg_wdata_i[0];
        CFG_STEP:   step_q   <= cfg_wdata_i[7:0];
        default:    layout_q <= layout_q;
      endcase
    end
  end

  cbm_front u_front (
    .layout_mode_i (layout_q),
    .operation_i   (operation_i),
    .address_i     (address_i),
    .write_data_i  (write_data_i),
    .cmd_o         (front_cmd)
  );

  cbm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_data_i  (front_cmd),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_pop),
    .pop_data_o   (queue_cmd),
    .stat_o       (queue_stat)
  );

  cbm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .line_step_i (step_q),
    .cmd_valid_i (queue_valid),
    .cmd_ready_o (queue_pop),
    .cmd_i       (queue_cmd),
    .res_valid_o (out_valid_o),
    .res_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign chr_update_o      = res.chr_update;
  assign chr_slot_o        = res.chr_slot;
  assign chr_bank_o        = res.chr_bank;
  assign prg_low_update_o  = res.prg_low_update;
  assign prg_low_bank_o    = res.prg_low_bank;
  assign prg_high_update_o = res.prg_high_update;
  assign prg_high_bank_o   = res.prg_high_bank;
  assign mirror_update_o   = res.mirror_update;
  assign mirror_mode_o     = res.mirror_mode;
  assign irq_fire_o        = res.irq_fire;

  // A full queue is never empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    queue_stat.full |-> !queue_stat.empty)
    else $error("queue reports full and empty together");

  // A command taken by the back end shows up as a result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!queue_stat.empty && (!out_valid_o || out_ready_i)) |=> out_valid_o)
    else $error("executed command produced no result");

  // An IRQ result never carries a mapping update
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && irq_fire_o) |->
      !(chr_update_o || prg_low_update_o || prg_high_update_o || mirror_update_o))
    else $error("irq result carries a mapping update");

  // CHR fields without their update flag read as zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !chr_update_o) |-> (chr_slot_o == '0 && chr_bank_o == '0))
    else $error("chr fields set without chr update");

endmodule

// ===== hw/rtl/cbm_front.sv =====
// Front end: classifies register writes and ticks into queue commands.
`timescale 1ns / 1ps

module cbm_front import cbm_pkg::*; (
  input  logic        layout_mode_i,
  input  logic        operation_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  output cmd_t        cmd_o
);

  logic [3:0] sel;

  assign sel = address_i[3:0];

  always_comb begin
    cmd_o.kind = CMD_NONE;
    cmd_o.slot = sel[2:0];
    cmd_o.data = write_data_i;
    if (operation_i == OpTick) begin
      cmd_o.kind = CMD_TICK;
    end else if (!layout_mode_i) begin
      // Nibble layout: any address, low nibble picks the register
      case (sel) inside
        [4'h0:4'h7]: cmd_o.kind = CMD_CHR;
        4'h8:        cmd_o.kind = CMD_PRG_DIRECT;
        4'h9:        cmd_o.kind = CMD_MIRROR;
        4'hA:        cmd_o.kind = CMD_IRQ_CTRL;
        4'hB:        cmd_o.kind = CMD_RELOAD_LO;
        4'hC:        cmd_o.kind = CMD_RELOAD_HI;
        default:     cmd_o.kind = CMD_NONE;
      endcase
    end else if (address_i[15:4] == FullBase) begin
      // Full-address layout with outer bank selects
      case (sel) inside
        [4'h0:4'h3]: cmd_o.kind = CMD_OUTER_LOW;
        [4'h4:4'h7]: cmd_o.kind = CMD_OUTER_HIGH;
        4'h8:        cmd_o.kind = CMD_INNER;
        4'h9:        cmd_o.kind = CMD_MIRROR;
        4'hA:        cmd_o.kind = CMD_IRQ_CTRL;
        4'hB:        cmd_o.kind = CMD_RELOAD_LO;
        4'hC:        cmd_o.kind = CMD_RELOAD_HI;
        default:     cmd_o.kind = CMD_NONE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/cbm_queue.sv =====
// Short command queue between the decode front end and the execute back end.
`timescale 1ns / 1ps

module cbm_queue import cbm_pkg::*; #(
  parameter int unsigned Depth = CbmQueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_valid_i,
  output logic        push_ready_o,
  input  cmd_t        push_data_i,
  output logic        pop_valid_o,
  input  logic        pop_ready_i,
  output cmd_t        pop_data_o,
  output queue_stat_t stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            store_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign stat_o.full  = (count_q == FullCnt);
  assign stat_o.empty = (count_q == '0);
  assign push_ready_o = !stat_o.full;
  assign pop_valid_o  = !stat_o.empty;
  assign pop_data_o   = store_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk_i) begin
    if (push) begin
      store_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/cbm_back.sv =====
// Back end: applies commands to mapper and IRQ state, holds the result register.
`timescale 1ns / 1ps

module cbm_back import cbm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] line_step_i,
  input  logic       cmd_valid_i,
  output logic       cmd_ready_o,
  input  cmd_t       cmd_i,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output result_t    res_o
);

  logic        irq_enable_q, irq_enable_d;
  logic [15:0] irq_count_q, irq_count_d;
  logic [15:0] irq_reload_q, irq_reload_d;
  logic        outer_low_q, outer_low_d;
  logic        outer_high_q, outer_high_d;
  logic [7:0]  inner_bank_q, inner_bank_d;
  logic        res_valid_q, res_valid_d;
  result_t     res_q, res_d;
  logic        take;
  logic [8:0]  low_sum;

  assign cmd_ready_o = !res_valid_q || res_ready_i;
  assign take        = cmd_valid_i && cmd_ready_o;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // Low window bank: outer select * 16 + inner bank (operands follow the command)
  always_comb begin
    logic       sel_bit;
    logic [7:0] inner;
    sel_bit = (cmd_i.kind == CMD_OUTER_LOW) ? cmd_i.data[0] : outer_low_q;
    inner   = (cmd_i.kind == CMD_INNER) ? cmd_i.data : inner_bank_q;
    low_sum = {4'b0, sel_bit, 4'b0} + {1'b0, inner};
  end

  // Execute one command
  always_comb begin
    irq_enable_d = irq_enable_q;
    irq_count_d  = irq_count_q;
    irq_reload_d = irq_reload_q;
    outer_low_d  = outer_low_q;
    outer_high_d = outer_high_q;
    inner_bank_d = inner_bank_q;
    res_d        = '0;
    case (cmd_i.kind)
      CMD_CHR: begin
        res_d.chr_update = 1'b1;
        res_d.chr_slot   = cmd_i.slot;
        res_d.chr_bank   = cmd_i.data;
      end
      CMD_PRG_DIRECT: begin
        res_d.prg_low_update = 1'b1;
        res_d.prg_low_bank   = {1'b0, cmd_i.data};
      end
      CMD_OUTER_LOW: begin
        outer_low_d          = cmd_i.data[0];
        res_d.prg_low_update = 1'b1;
        res_d.prg_low_bank   = low_sum;
      end
      CMD_OUTER_HIGH: begin
        outer_high_d          = cmd_i.data[0];
        res_d.prg_high_update = 1'b1;
        res_d.prg_high_bank   = {cmd_i.data[0], 4'hF};
      end
      CMD_INNER: begin
        inner_bank_d          = cmd_i.data;
        res_d.prg_low_update  = 1'b1;
        res_d.prg_low_bank    = low_sum;
        res_d.prg_high_update = 1'b1;
        res_d.prg_high_bank   = {outer_high_q, 4'hF};
      end
      CMD_MIRROR: begin
        res_d.mirror_update = 1'b1;
        res_d.mirror_mode   = cmd_i.data[1:0];
      end
      CMD_IRQ_CTRL: begin
        irq_enable_d = cmd_i.data[0];
        irq_count_d  = irq_reload_q;
      end
      CMD_RELOAD_LO: irq_reload_d = {irq_reload_q[15:8], cmd_i.data};
      CMD_RELOAD_HI: irq_reload_d = {cmd_i.data, irq_reload_q[7:0]};
      CMD_TICK: begin
        // Count down; fire and park at all ones once the step covers the rest
        if (irq_enable_q) begin
          if (irq_count_q <= {8'b0, line_step_i}) begin
            res_d.irq_fire = 1'b1;
            irq_count_d    = 16'hFFFF;
            irq_enable_d   = 1'b0;
          end else begin
            irq_count_d = irq_count_q - {8'b0, line_step_i};
          end
        end
      end
      default: res_d = '0;
    endcase
    if (take) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end else begin
      res_valid_d = res_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irq_enable_q <= 1'b0;
      irq_count_q  <= '0;
      irq_reload_q <= '0;
      outer_low_q  <= 1'b0;
      outer_high_q <= 1'b0;
      inner_bank_q <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (take) begin
        irq_enable_q <= irq_enable_d;
        irq_count_q  <= irq_count_d;
        irq_reload_q <= irq_reload_d;
        outer_low_q  <= outer_low_d;
        outer_high_q <= outer_high_d;
        inner_bank_q <= inner_bank_d;
      end
    end
  end

  // Result payload, no reset
  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

endmodule

// ===== verif/tb_cartridge_bank_mapper_with_irq.sv =====
// Self-checking testbench for the cartridge bank mapper with scanline IRQ counter.
`timescale 1ns / 1ps

module tb_cartridge_bank_mapper_with_irq;
  import cbm_pkg::*;

  // Register layouts
  localparam logic LayoutNibble = 1'b0;
  localparam logic LayoutFull   = 1'b1;

  // Low-nibble register selects
  localparam logic [3:0] SelOuterHi  = 4'h4;
  localparam logic [3:0] SelPrg      = 4'h8;
  localparam logic [3:0] SelMirror   = 4'h9;
  localparam logic [3:0] SelIrqCtrl  = 4'hA;
  localparam logic [3:0] SelReloadLo = 4'hB;
  localparam logic [3:0] SelReloadHi = 4'hC;

  localparam int unsigned ResetCycles = 9;
  localparam int unsigned IdlePct     = 30;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned PhaseItems  = 190;
  localparam int unsigned TimeoutNs   = 2_000_000;

  localparam result_t Quiet = '0;

  logic                clk_i;
  logic                rst_ni       = 1'b0;
  logic                cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i    = '0;
  logic [CfgDataW-1:0] cfg_wdata_i  = '0;
  logic                in_valid_i   = 1'b0;
  logic                in_ready_o;
  logic                operation_i  = 1'b0;
  logic [15:0]         address_i    = '0;
  logic [7:0]          write_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i  = 1'b0;
  logic                chr_update_o;
  logic [2:0]          chr_slot_o;
  logic [7:0]          chr_bank_o;
  logic                prg_low_update_o;
  logic [8:0]          prg_low_bank_o;
  logic                prg_high_update_o;
  logic [4:0]          prg_high_bank_o;
  logic                mirror_update_o;
  logic [1:0]          mirror_mode_o;
  logic                irq_fire_o;

  cartridge_bank_mapper_with_irq dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Mapper shadow: configuration, IRQ counter, outer bank selects and inner bank
  logic        cur_layout = LayoutNibble;
  logic [7:0]  cur_step   = StepReset;
  logic        irq_armed  = 1'b0;
  logic [15:0] irq_left   = '0;
  logic [15:0] reload_val = '0;
  logic        outer_lo   = 1'b0;
  logic        outer_hi   = 1'b0;
  logic [7:0]  inner_bank = '0;

  result_t     pending_updates [$];
  int unsigned fail_count = 0;
  int unsigned sent_count = 0;
  bit          stall_en   = 1'b1;

  // Directed rows; typed = 1 means want is checked instead of the shadow's answer
  typedef struct {
    logic        layout;
    logic        op;
    logic [15:0] addr;
    logic [7:0]  data;
    bit          typed;
    result_t     want;
  } dir_row_t;

  dir_row_t dir_rows [27] = '{
    // tick right after reset: IRQ disabled
    '{LayoutNibble, OpTick,  16'h0000, 8'h00, 1'b1, Quiet},
    '{LayoutNibble, OpWrite, 16'h0000, 8'hFF, 1'b1,
      '{chr_update: 1'b1, chr_slot: 3'd0, chr_bank: 8'hFF, default: '0}},
    '{LayoutNibble, OpWrite, 16'hFFF7, 8'h00, 1'b1,
      '{chr_update: 1'b1, chr_slot: 3'd7, default: '0}},
    '{LayoutNibble, OpWrite, 16'h1238, 8'hFF, 1'b1,
      '{prg_low_update: 1'b1, prg_low_bank: 9'd255, default: '0}},
    '{LayoutNibble, OpWrite, 16'hABC9, 8'hFE, 1'b1,
      '{mirror_update: 1'b1, mirror_mode: 2'd2, default: '0}},
    // unmapped nibbles
    '{LayoutNibble, OpWrite, 16'h000D, 8'hFF, 1'b1, Quiet},
    '{LayoutNibble, OpWrite, 16'h7FFE, 8'h00, 1'b1, Quiet},
    '{LayoutNibble, OpWrite, 16'hFFFF, 8'hA5, 1'b1, Quiet},
    // reload 0x0100, arm, count down to the IRQ, then one tick while disabled
    '{LayoutNibble, OpWrite, 16'h000B, 8'h00, 1'b1, Quiet},
    '{LayoutNibble, OpWrite, 16'h000C, 8'h01, 1'b1, Quiet},
    '{LayoutNibble, OpWrite, 16'h000A, 8'h01, 1'b1, Quiet},
    '{LayoutNibble, OpTick,  16'hFFFF, 8'hFF, 1'b0, Quiet},
    '{LayoutNibble, OpTick,  16'h0000, 8'h00, 1'b0, Quiet},
    '{LayoutNibble, OpTick,  16'h0000, 8'h00, 1'b0, Quiet},
    '{LayoutNibble, OpTick,  16'h0000, 8'h00, 1'b0, Quiet},
    // full-address layout: outer and inner selects
    '{LayoutFull, OpWrite, 16'h8000, 8'h01, 1'b1,
      '{prg_low_update: 1'b1, prg_low_bank: 9'd16, default: '0}},
    '{LayoutFull, OpWrite, 16'h8004, 8'hFF, 1'b1,
      '{prg_high_update: 1'b1, prg_high_bank: 5'd31, default: '0}},
    '{LayoutFull, OpWrite, 16'h8008, 8'hFF, 1'b1,
      '{prg_low_update: 1'b1, prg_low_bank: 9'd271,
        prg_high_update: 1'b1, prg_high_bank: 5'd31, default: '0}},
    '{LayoutFull, OpWrite, 16'h8003, 8'h00, 1'b0, Quiet},
    '{LayoutFull, OpWrite, 16'h8007, 8'hFE, 1'b0, Quiet},
    '{LayoutFull, OpWrite, 16'h8009, 8'h01, 1'b0, Quiet},
    // unmapped select 0x800D, then writes outside the register window
    '{LayoutFull, OpWrite, 16'h800D, 8'hFF, 1'b1, Quiet},
    '{LayoutFull, OpWrite, 16'h0008, 8'hFF, 1'b1, Quiet},
    '{LayoutFull, OpWrite, 16'h8010, 8'hFF, 1'b1, Quiet},
    // reload of zero fires on the first tick
    '{LayoutFull, OpWrite, 16'h800C, 8'h00, 1'b1, Quiet},
    '{LayoutFull, OpWrite, 16'h800A, 8'h03, 1'b1, Quiet},
    '{LayoutFull, OpTick,  16'h0000, 8'h00, 1'b0, Quiet}
  };

  // Random phases: layout, step and whether both sides may stall
  typedef struct {
    logic       layout;
    logic [7:0] step;
    bit         rand_step;
    bit         stalls;
  } phase_t;

  phase_t phases [8] = '{
    '{LayoutFull,   8'd113, 1'b0, 1'b1},
    '{LayoutNibble, 8'd255, 1'b0, 1'b1},
    '{LayoutFull,   8'd1,   1'b0, 1'b1},
    '{LayoutNibble, 8'd0,   1'b0, 1'b1},
    '{LayoutFull,   8'd114, 1'b0, 1'b0},
    '{LayoutNibble, 8'd0,   1'b1, 1'b1},
    '{LayoutFull,   8'd0,   1'b1, 1'b1},
    '{LayoutNibble, 8'd114, 1'b0, 1'b1}
  };

  // Bank and IRQ update caused by one item; advances the shadow state
  function automatic result_t map_outcome(input logic op, input logic [15:0] addr,
                                          input logic [7:0] data);
    result_t    r;
    logic [3:0] sel;
    r   = '0;
    sel = addr[3:0];
    if (op == OpTick) begin
      if (irq_armed) begin
        if (irq_left <= {8'h00, cur_step}) begin
          r.irq_fire = 1'b1;
          irq_left   = 16'hFFFF;
          irq_armed  = 1'b0;
        end else begin
          irq_left = irq_left - {8'h00, cur_step};
        end
      end
    end else if (cur_layout == LayoutNibble && sel < SelPrg) begin
      r.chr_update = 1'b1;
      r.chr_slot   = sel[2:0];
      r.chr_bank   = data;
    end else if (cur_layout == LayoutNibble && sel == SelPrg) begin
      r.prg_low_update = 1'b1;
      r.prg_low_bank   = {1'b0, data};
    end else if (cur_layout == LayoutFull && addr[15:4] != FullBase) begin
      // outside the register window: nothing happens
    end else if (cur_layout == LayoutFull && sel <= SelPrg) begin
      if (sel < SelOuterHi) outer_lo = data[0];
      else if (sel < SelPrg) outer_hi = data[0];
      else inner_bank = data;
      r.prg_low_update  = (sel < SelOuterHi) || (sel == SelPrg);
      r.prg_high_update = (sel >= SelOuterHi);
      if (r.prg_low_update) r.prg_low_bank = {4'h0, outer_lo, 4'h0} + {1'b0, inner_bank};
      if (r.prg_high_update) r.prg_high_bank = {outer_hi, 4'hF};
    end else begin
      case (sel)
        SelMirror: begin
          r.mirror_update = 1'b1;
          r.mirror_mode   = data[1:0];
        end
        SelIrqCtrl: begin
          irq_armed = data[0];
          irq_left  = reload_val;
        end
        SelReloadLo: reload_val[7:0]  = data;
        SelReloadHi: reload_val[15:8] = data;
        default: ;
      endcase
    end
    return r;
  endfunction

  // Register address for the current layout
  function automatic logic [15:0] reg_addr(input logic [3:0] sel);
    if (cur_layout == LayoutFull) return {FullBase, sel};
    return {12'($urandom), sel};
  endfunction

  // One input transfer, with a random idle gap ahead of it
  task automatic send_item(input logic op, input logic [15:0] addr, input logic [7:0] data,
                           input bit typed = 1'b0, input result_t typed_want = '0);
    result_t     predicted;
    int unsigned gap;
    gap = 0;
    if (stall_en) begin
      while ($urandom_range(99) < IdlePct) gap++;
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    address_i    <= addr;
    write_data_i <= data;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = map_outcome(op, addr, data);
    pending_updates.push_back(typed ? typed_want : predicted);
    sent_count++;
  endtask

  // Both registers are written once the block has drained
  task automatic set_config(input logic layout, input logic [7:0] step);
    in_valid_i <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_LAYOUT;
    cfg_wdata_i <= {7'd0, layout};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_STEP;
    cfg_wdata_i <= step;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cur_layout = layout;
    cur_step   = step;
  endtask

  // Mostly IRQ arm-and-count sequences and bank writes, plus raw noise
  task automatic run_phase(input int unsigned quota);
    int unsigned first;
    int unsigned pick;
    int unsigned ticks;
    first = sent_count;
    while (sent_count - first < quota) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        send_item(OpWrite, reg_addr(SelReloadLo), 8'($urandom));
        send_item(OpWrite, reg_addr(SelReloadHi),
                  ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(3)));
        send_item(OpWrite, reg_addr(SelIrqCtrl), {7'($urandom), ($urandom_range(4) != 0)});
        ticks = ($urandom_range(9) == 0) ? $urandom_range(80, 40) : $urandom_range(12, 1);
        repeat (ticks) begin
          if ($urandom_range(99) < 15) send_item(OpWrite, reg_addr(4'($urandom)), 8'($urandom));
          else send_item(OpTick, 16'($urandom), 8'($urandom));
        end
      end else if (pick < 80) begin
        send_item(OpWrite, reg_addr(4'($urandom)), 8'($urandom));
      end else begin
        send_item(1'($urandom), 16'($urandom), 8'($urandom));
      end
    end
  endtask

  task automatic cmp_field(input string name, input logic [8:0] want, input logic [8:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // Result side: check each transfer, then pick the next ready
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_updates.size() == 0) begin
        $error("result transfer with no expected update pending");
        fail_count++;
      end else begin
        want = pending_updates.pop_front();
        cmp_field("chr_update", 9'(want.chr_update), 9'(chr_update_o));
        cmp_field("chr_slot", 9'(want.chr_slot), 9'(chr_slot_o));
        cmp_field("chr_bank", 9'(want.chr_bank), 9'(chr_bank_o));
        cmp_field("prg_low_update", 9'(want.prg_low_update), 9'(prg_low_update_o));
        cmp_field("prg_low_bank", want.prg_low_bank, prg_low_bank_o);
        cmp_field("prg_high_update", 9'(want.prg_high_update), 9'(prg_high_update_o));
        cmp_field("prg_high_bank", 9'(want.prg_high_bank), 9'(prg_high_bank_o));
        cmp_field("mirror_update", 9'(want.mirror_update), 9'(mirror_update_o));
        cmp_field("mirror_mode", 9'(want.mirror_mode), 9'(mirror_mode_o));
        cmp_field("irq_fire", 9'(want.irq_fire), 9'(irq_fire_o));
      end
    end
    out_ready_i <= !stall_en || ($urandom_range(99) >= IdlePct);
  end

  // Run limit
  initial begin
    #(TimeoutNs);
    $display("Regression FAIL");
    $finish;
  end

  // Stimulus sequence
  initial begin
    logic [7:0] step;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].layout != cur_layout) set_config(dir_rows[i].layout, cur_step);
      send_item(dir_rows[i].op, dir_rows[i].addr, dir_rows[i].data,
                dir_rows[i].typed, dir_rows[i].want);
    end

    foreach (phases[p]) begin
      step = phases[p].rand_step ? 8'($urandom_range(255, 1)) : phases[p].step;
      set_config(phases[p].layout, step);
      stall_en = phases[p].stalls;
      run_phase(PhaseItems);
    end

    in_valid_i <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
